@@ rtl/pctd_pkg.sv @@
package pctd_pkg;

   localparam int ValW   = 32;               // input word width
   localparam int NumW   = ValW - 1;         // magnitude of a positive value
   localparam int DivW   = 16;               // trial divisor, never above 46341
   localparam int CntW   = $clog2(NumW);     // bit counter of the serial divider
   localparam int SqW    = 32;               // square of the trial divisor
   localparam int TallyW = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic            start;
      logic [NumW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic done;
      logic zero;
   } rem_stat_type;

endpackage

@@ rtl/pctd_if.sv @@
interface pctd_req_if;
   import pctd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [ValW-1:0] value;
   logic                   last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface pctd_rsp_if;
   import pctd_pkg::*;

   logic              valid;
   logic              ready;
   logic [TallyW-1:0] prime_count;

   modport source (output valid, output prime_count, input ready);
   modport sink   (input valid, input prime_count, output ready);
endinterface

@@ rtl/pctd_rem.sv @@
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module pctd_rem (
   input  logic                  clock,
   input  logic                  reset,
   input  pctd_pkg::rem_cmd_type cmd,
   output pctd_pkg::rem_stat_type stat
);
   import pctd_pkg::*;

   logic [NumW-1:0] dvd_ff, dvd_in;
   logic [DivW-1:0] rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW:0]   trial;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, dvd_ff[NumW-1]};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         dvd_in  = cmd.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, cmd.divisor}) begin
            rem_in = DivW'(trial - {1'b0, cmd.divisor});
         end else begin
            rem_in = trial[DivW-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(NumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);

endmodule

@@ rtl/prime_count_trial_division.sv @@
// Channel   Dir  Payload                        Handshake
// req_chan  in   value[31:0] signed, last_item  valid / ready
// rsp_chan  out  prime_count[31:0]              valid / ready
//
// One word at a time. A value of 1 or less goes straight to ST_FINISH. A value n > 1
// tries divisors from 2 up to floor(sqrt n), stopping at the first factor of a
// composite; each divisor is set up in ST_CHECK, runs through the bit-serial
// remainder unit one dividend bit at a time, and its result is read in ST_DIV.
// Reset clears the tally, the state machine and the valid flag of the result register.
// A finished tally waits in the result register while the next list is taken in;
// only a further word marked last stalls until that register is free.
module prime_count_trial_division (
   input  logic       clock,
   input  logic       reset,
   pctd_req_if.sink   req_chan,
   pctd_rsp_if.source rsp_chan
);
   import pctd_pkg::*;

   state_type         state_ff, state_in;
   logic [NumW-1:0]   num_ff, num_in;
   logic              last_ff, last_in;
   logic              prime_ff, prime_in;
   logic [DivW-1:0]   div_ff, div_in;
   logic [SqW-1:0]    sq_ff, sq_in;
   logic [TallyW-1:0] tally_ff, tally_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TallyW-1:0] rsp_count_ff, rsp_count_in;
   logic [TallyW-1:0] tally_sum;
   logic              slot_free;
   rem_cmd_type       rem_cmd;
   rem_stat_type      rem_stat;

   pctd_rem u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .stat  (rem_stat)
   );

   // tally including the current word, held at its maximum
   assign tally_sum = (prime_ff && tally_ff != '1) ? tally_ff + 1'b1 : tally_ff;
   // result register can take a new word this cycle
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      last_in      = last_ff;
      prime_in     = prime_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      tally_in     = tally_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in = rsp_count_ff;
      rem_cmd.start    = 1'b0;
      rem_cmd.dividend = num_ff;
      rem_cmd.divisor  = div_ff;
      req_chan.ready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               num_in  = req_chan.value[NumW-1:0];
               last_in = req_chan.last_item;
               div_in  = DivW'(2);
               sq_in   = SqW'(4);
               // negative, zero and one are never prime
               if (req_chan.value[ValW-1] || req_chan.value[NumW-1:0] <= NumW'(1)) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // past the square root without a divisor: prime
            if (sq_ff > {1'b0, num_ff}) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rem_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  div_in   = div_ff + 1'b1;
                  sq_in    = sq_ff + SqW'({div_ff, 1'b1});
                  state_in = ST_CHECK;
               end
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               tally_in = tally_sum;
               state_in = ST_IDLE;
            end else if (slot_free) begin
               // emit the list's count and start a fresh tally
               rsp_valid_in = 1'b1;
               rsp_count_in = tally_sum;
               tally_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff       <= num_in;
      last_ff      <= last_in;
      prime_ff     <= prime_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prime_count = rsp_count_ff;

endmodule

@@ rtl/pctd_check.sv @@
module pctd_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pctd_pkg::TallyW-1:0] rsp_count
);
   import pctd_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       last_acc, rsp_acc;

   assign last_acc = req_valid && req_ready && req_last;
   assign rsp_acc  = rsp_valid && rsp_ready;

   // words marked last taken in but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (last_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (!last_acc && rsp_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
      else $error("result word changed while stalled");

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after accepting a word");

   a_rsp_has_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a closed list");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many closed lists held back");

endmodule

bind prime_count_trial_division pctd_check u_pctd_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_item),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_count (rsp_chan.prime_count)
);

@@ sim/tb_prime_count_trial_division.sv @@
`timescale 1ns / 100ps

module tb_prime_count_trial_division;
   import pctd_pkg::*;

   localparam int QuietLimit = 8_000_000;  // must outlast the check of a prime near 2^31
   localparam int HoldCycles = 2000;
   localparam int TailCycles = 200;

   logic clock;
   logic reset;

   pctd_req_if req_if ();
   pctd_rsp_if rsp_if ();

   prime_count_trial_division i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Prediction state: running tally of primes and the counts still owed.
   logic [TallyW-1:0] tally_model;
   logic [TallyW-1:0] expected_counts[$];

   int  mismatch_count;
   int  idle_pct;
   int  stall_pct;
   bit  hold_request;
   int  hold_count;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Trial division over the signed value; stop at the square root.
   function automatic bit is_prime_value(logic [ValW-1:0] word);
      longint n;
      longint d;
      n = $signed(word);
      if (n <= 1)
         return 1'b0;
      for (d = 2; d * d <= n && d <= n / 2; d++) begin
         if (n % d == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advance the tally for one accepted word; owe a count when the list closes.
   function automatic void tally_word(logic [ValW-1:0] word, logic last);
      if (is_prime_value(word) && tally_model != '1)
         tally_model++;
      if (last) begin
         expected_counts.push_back(tally_model);
         tally_model = '0;
      end
   endfunction

   // Mostly small values, so primes are common and cheap; large positives are
   // forced composite with a small factor to keep the division short.
   function automatic logic [ValW-1:0] random_element();
      logic [31:0] r32;
      int          pick;
      r32  = $urandom;
      pick = $urandom_range(99);
      if (pick < 35)
         return $urandom_range(300, 0);
      else if (pick < 55)
         return $urandom_range(3000, 300);
      else if (pick < 62)
         return $urandom_range(70000, 3000);
      else if (pick < 78)
         return {1'b1, r32[30:0]};
      else if (pick < 88)
         return {1'b0, r32[30:1], 1'b0};
      else if (pick < 94)
         return -$urandom_range(10, 0);
      else
         return 32'($urandom_range(715827882, 1)) * 32'd3;
   endfunction

   // Offer one word, idling first at the current rate; return once accepted.
   task automatic send_word(logic [ValW-1:0] word, logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.value     <= word;
      req_if.last_item <= last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      tally_word(word, last);
   endtask

   // Drop valid and wait until every owed count has come back.
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_list(logic [ValW-1:0] words[$]);
      foreach (words[i])
         send_word(words[i], i == words.size() - 1);
   endtask

   // Extremes of the value, the non-positive range, the empty divisor range
   // of two and three, squares on the square-root boundary, and the largest
   // positive value, which is prime and walks the divisor to its top.
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      send_list({32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000});
      send_list({32'd2, 32'd3});
      send_list({32'd4, 32'd9, 32'd25, 32'd49});
      send_list({32'd5, 32'd97, 32'd63001, 32'd65537});
      send_list({32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555});
      send_list({32'h7FFF_FFFF});
   endtask

   task automatic test_random_lists(int quota, int idle, int stall);
      int sent;
      int len;
      idle_pct  = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < quota) begin
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(10, 1);
         for (int i = 0; i < len; i++)
            send_word(random_element(), i == len - 1);
         sent += len;
      end
   endtask

   // Hold the result side off while several short lists go in, so the
   // result register fills and the next last word stalls; then pause the
   // sender until everything owed has come back.
   task automatic test_stall_and_drain();
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 1'b1;
      for (int l = 0; l < 4; l++) begin
         for (int i = 0; i < 6; i++)
            send_word($urandom_range(40, 0), i == 5);
      end
      drain();
      send_list({32'd7, 32'd11, 32'd12});
      drain();
   endtask

   // Result side: stall at the current rate, or hold off for a long stretch.
   always @(negedge clock) begin
      if (hold_request) begin
         rsp_if.ready <= 1'b0;
         hold_count++;
         if (hold_count >= HoldCycles) begin
            hold_count   = 0;
            hold_request = 1'b0;
         end
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Check every accepted count against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_counts.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected prime_count, expected none, actual %0d",
                     $time, rsp_if.prime_count);
         end else begin
            if (rsp_if.prime_count !== expected_counts[0]) begin
               mismatch_count++;
               $display("%0t: prime_count mismatch, expected %0d, actual %0d",
                        $time, expected_counts[0], rsp_if.prime_count);
            end
            void'(expected_counts.pop_front());
         end
      end
   end

   // Watchdog: give up after a long run of cycles with no word moving.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no progress for %0d cycles", $time, QuietLimit);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.value     = '0;
      req_if.last_item = 1'b0;
      rsp_if.ready     = 1'b0;
      tally_model      = '0;
      mismatch_count   = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      hold_request     = 1'b0;
      hold_count       = 0;
      quiet_cycles     = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_lists(480, 0, 0);
      test_random_lists(470, 75, 0);
      test_stall_and_drain();
      test_random_lists(470, 0, 75);
      test_random_lists(470, 7, 7);

      drain();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/pctd_pkg.sv
rtl/pctd_if.sv
rtl/pctd_rem.sv
rtl/prime_count_trial_division.sv
rtl/pctd_check.sv
sim/tb_prime_count_trial_division.sv
